/* sv/wsee_pkg.sv */
// ----------------------------------------------------------------------------
// Windowed standard deviation estimator package
// Shared widths, constants, operation codes and control structures.
// ----------------------------------------------------------------------------
package wsee_pkg;

    localparam int WINDOW      = 100;
    localparam int SAMPLE_W    = 12;
    localparam int SUM_W       = 14;
    localparam int TOTAL_W     = 21;
    localparam int SQUARES_W   = 35;
    localparam int SLOT_W      = $clog2(WINDOW);
    localparam int FILL_W      = $clog2(WINDOW + 1);
    localparam int NQ_W        = SQUARES_W + $clog2(WINDOW + 1);
    localparam int SS_W        = 2 * TOTAL_W;
    localparam int DIFF_W      = (NQ_W > SS_W) ? NQ_W : SS_W;
    localparam int FRAC_SHIFT  = 16;
    localparam int RAD_W       = ((DIFF_W + FRAC_SHIFT + 1) / 2) * 2;
    localparam int ROOT_W      = RAD_W / 2;
    localparam int REM_W       = ROOT_W + 2;
    localparam int RECIP_SHIFT = ROOT_W + $clog2(WINDOW);
    localparam int RECIP_W     = ROOT_W + 1;
    localparam int PROD_W      = ROOT_W + RECIP_W;
    localparam int SQRT_CNT_W  = $clog2(ROOT_W);
    localparam int STD_W       = 21;
    localparam int GAIN_W      = 24;
    localparam int OFFSET_W    = 32;
    localparam int ENERGY_W    = 38;
    localparam int GAIN_FRAC   = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 64;

    localparam logic [RECIP_W-1:0]  RECIP        = RECIP_W'((64'd1 << RECIP_SHIFT) / WINDOW);
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 32'd1212997549;
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 24'd1889786;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ENERGY_OFFSET = 2'd0,
        CFG_ENERGY_GAIN   = 2'd1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_SQ_OLD,
        OP_SQ_NEW,
        OP_ACC,
        OP_NQ,
        OP_SS,
        OP_DIFF,
        OP_SQRT,
        OP_DIV,
        OP_QEST,
        OP_QFIX,
        OP_GAIN,
        OP_FINISH
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_OLD,
        ST_SQ_NEW,
        ST_ACC,
        ST_NQ,
        ST_SS,
        ST_DIFF,
        ST_SQRT,
        ST_DIV,
        ST_QEST,
        ST_QFIX,
        ST_GAIN,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic fill_last;
        logic out_stall;
    } dp_status_t;

endpackage

/* sv/wsee_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wsee_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/wsee_ctrl.sv */
// ----------------------------------------------------------------------------
// Estimator controller
// Sequences ring update, accumulation, square root, scaling and output load.
// ----------------------------------------------------------------------------
module wsee_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  wsee_pkg::dp_status_t dp_stat,
    output wsee_pkg::dp_cmd_t    dp_cmd
);

    wsee_pkg::ctrl_state_t              state_reg, state_next;
    logic [wsee_pkg::SQRT_CNT_W-1:0]    cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wsee_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        dp_cmd.op  = wsee_pkg::OP_IDLE;
        s_tready   = 1'b0;
        cnt_next   = '0;
        unique case (state_reg)
            wsee_pkg::ST_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    dp_cmd.op  = wsee_pkg::OP_LOAD;
                    state_next = wsee_pkg::ST_SQ_OLD;
                end
            end
            wsee_pkg::ST_SQ_OLD: begin
                dp_cmd.op  = wsee_pkg::OP_SQ_OLD;
                state_next = wsee_pkg::ST_SQ_NEW;
            end
            wsee_pkg::ST_SQ_NEW: begin
                dp_cmd.op  = wsee_pkg::OP_SQ_NEW;
                state_next = wsee_pkg::ST_ACC;
            end
            wsee_pkg::ST_ACC: begin
                dp_cmd.op  = wsee_pkg::OP_ACC;
                state_next = dp_stat.fill_last ? wsee_pkg::ST_NQ : wsee_pkg::ST_FINISH;
            end
            wsee_pkg::ST_NQ: begin
                dp_cmd.op  = wsee_pkg::OP_NQ;
                state_next = wsee_pkg::ST_SS;
            end
            wsee_pkg::ST_SS: begin
                dp_cmd.op  = wsee_pkg::OP_SS;
                state_next = wsee_pkg::ST_DIFF;
            end
            wsee_pkg::ST_DIFF: begin
                dp_cmd.op  = wsee_pkg::OP_DIFF;
                state_next = wsee_pkg::ST_SQRT;
            end
            wsee_pkg::ST_SQRT: begin
                dp_cmd.op = wsee_pkg::OP_SQRT;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == wsee_pkg::SQRT_CNT_W'(wsee_pkg::ROOT_W - 1)) begin
                    cnt_next   = '0;
                    state_next = wsee_pkg::ST_DIV;
                end
            end
            wsee_pkg::ST_DIV: begin
                dp_cmd.op  = wsee_pkg::OP_DIV;
                state_next = wsee_pkg::ST_QEST;
            end
            wsee_pkg::ST_QEST: begin
                dp_cmd.op  = wsee_pkg::OP_QEST;
                state_next = wsee_pkg::ST_QFIX;
            end
            wsee_pkg::ST_QFIX: begin
                dp_cmd.op  = wsee_pkg::OP_QFIX;
                state_next = wsee_pkg::ST_GAIN;
            end
            wsee_pkg::ST_GAIN: begin
                dp_cmd.op  = wsee_pkg::OP_GAIN;
                state_next = wsee_pkg::ST_FINISH;
            end
            wsee_pkg::ST_FINISH: begin
                if (!dp_stat.out_stall) begin
                    dp_cmd.op  = wsee_pkg::OP_FINISH;
                    state_next = wsee_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wsee_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* sv/wsee_datapath.sv */
// ----------------------------------------------------------------------------
// Estimator datapath
// Sum ring, running sums, shared multiplier, bit-serial square root,
// reciprocal division, configuration registers and output register.
// ----------------------------------------------------------------------------
module wsee_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  wsee_pkg::dp_cmd_t                   dp_cmd,
    output wsee_pkg::dp_status_t                dp_stat,
    input  logic [wsee_pkg::SAMPLE_W-1:0]       pressure_a,
    input  logic [wsee_pkg::SAMPLE_W-1:0]       pressure_b,
    input  logic [wsee_pkg::SAMPLE_W-1:0]       pressure_c,
    input  logic [wsee_pkg::SAMPLE_W-1:0]       pressure_d,
    input  logic                                cfg_valid,
    input  logic [wsee_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [wsee_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic                                ready_res,
    output logic [wsee_pkg::STD_W-1:0]          std_dev,
    output logic [wsee_pkg::ENERGY_W-1:0]       energy
);

    logic [wsee_pkg::SUM_W-1:0]     sum_reg, sum_next;
    logic [wsee_pkg::SLOT_W-1:0]    slot_reg, slot_next;
    logic [wsee_pkg::FILL_W-1:0]    fill_reg, fill_next;
    logic [wsee_pkg::TOTAL_W-1:0]   total_reg, total_next;
    logic [wsee_pkg::SQUARES_W-1:0] squares_reg, squares_next;
    logic [wsee_pkg::PROD_W-1:0]    prod_reg, prod_next;
    logic [wsee_pkg::NQ_W-1:0]      nq_reg, nq_next;
    logic [wsee_pkg::RAD_W-1:0]     rad_reg, rad_next;
    logic [wsee_pkg::ROOT_W-1:0]    root_reg, root_next;
    logic [wsee_pkg::REM_W-1:0]     rem_reg, rem_next;
    logic [wsee_pkg::ROOT_W-1:0]    q_reg, q_next;
    logic [wsee_pkg::STD_W-1:0]     sd_reg, sd_next;
    logic                           full_res_reg, full_res_next;
    logic [wsee_pkg::OFFSET_W-1:0]  offset_reg, offset_next;
    logic [wsee_pkg::GAIN_W-1:0]    gain_reg, gain_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           out_ready_reg, out_ready_next;
    logic [wsee_pkg::STD_W-1:0]     out_std_reg, out_std_next;
    logic [wsee_pkg::ENERGY_W-1:0]  out_energy_reg, out_energy_next;

    logic [wsee_pkg::SUM_W-1:0]     old_sum;
    logic [wsee_pkg::SUM_W-1:0]     in_sum;
    logic                           window_full;
    logic [wsee_pkg::ROOT_W-1:0]    mul_a;
    logic [wsee_pkg::RECIP_W-1:0]   mul_b;
    logic [wsee_pkg::PROD_W-1:0]    mul_p;
    logic [wsee_pkg::DIFF_W-1:0]    nq_ext;
    logic [wsee_pkg::DIFF_W-1:0]    ss_ext;
    logic [wsee_pkg::DIFF_W-1:0]    diff;
    logic [wsee_pkg::REM_W-1:0]     rem_trial;
    logic [wsee_pkg::REM_W-1:0]     root_trial;
    logic [wsee_pkg::ROOT_W-1:0]    q_resid;
    logic [wsee_pkg::ENERGY_W-1:0]  energy_calc;

    wsee_ram #(
        .WIDTH(wsee_pkg::SUM_W),
        .DEPTH(wsee_pkg::WINDOW)
    ) u_ring (
        .aclk   (aclk),
        .wr_en  (dp_cmd.op == wsee_pkg::OP_SQ_NEW),
        .wr_addr(slot_reg),
        .wr_data(sum_reg),
        .rd_en  (dp_cmd.op == wsee_pkg::OP_LOAD),
        .rd_addr(slot_reg),
        .rd_data(old_sum)
    );

    assign in_sum = wsee_pkg::SUM_W'(pressure_a) + wsee_pkg::SUM_W'(pressure_b)
                  + wsee_pkg::SUM_W'(pressure_c) + wsee_pkg::SUM_W'(pressure_d);
    assign window_full = (fill_reg == wsee_pkg::FILL_W'(wsee_pkg::WINDOW));

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (dp_cmd.op)
            wsee_pkg::OP_SQ_OLD: begin
                mul_a = wsee_pkg::ROOT_W'(old_sum);
                mul_b = wsee_pkg::RECIP_W'(old_sum);
            end
            wsee_pkg::OP_SQ_NEW: begin
                mul_a = wsee_pkg::ROOT_W'(sum_reg);
                mul_b = wsee_pkg::RECIP_W'(sum_reg);
            end
            wsee_pkg::OP_SS: begin
                mul_a = wsee_pkg::ROOT_W'(total_reg);
                mul_b = wsee_pkg::RECIP_W'(total_reg);
            end
            wsee_pkg::OP_DIV: begin
                mul_a = root_reg;
                mul_b = wsee_pkg::RECIP;
            end
            wsee_pkg::OP_GAIN: begin
                mul_a = wsee_pkg::ROOT_W'(sd_reg);
                mul_b = wsee_pkg::RECIP_W'(gain_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = wsee_pkg::PROD_W'(mul_a) * wsee_pkg::PROD_W'(mul_b);

    assign nq_ext     = wsee_pkg::DIFF_W'(nq_reg);
    assign ss_ext     = wsee_pkg::DIFF_W'(prod_reg[wsee_pkg::SS_W-1:0]);
    assign diff       = (nq_ext > ss_ext) ? (nq_ext - ss_ext) : '0;
    assign rem_trial  = {rem_reg[wsee_pkg::REM_W-3:0], rad_reg[wsee_pkg::RAD_W-1 -: 2]};
    assign root_trial = {root_reg, 2'b01};
    assign q_resid    = root_reg
                      - wsee_pkg::ROOT_W'(q_reg * wsee_pkg::ROOT_W'(wsee_pkg::WINDOW));
    assign energy_calc = wsee_pkg::ENERGY_W'(offset_reg)
                       + wsee_pkg::ENERGY_W'(prod_reg >> wsee_pkg::GAIN_FRAC);

    always_comb begin
        sum_next        = sum_reg;
        slot_next       = slot_reg;
        fill_next       = fill_reg;
        total_next      = total_reg;
        squares_next    = squares_reg;
        prod_next       = prod_reg;
        nq_next         = nq_reg;
        rad_next        = rad_reg;
        root_next       = root_reg;
        rem_next        = rem_reg;
        q_next          = q_reg;
        sd_next         = sd_reg;
        full_res_next   = full_res_reg;
        offset_next     = offset_reg;
        gain_next       = gain_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_ready_next  = out_ready_reg;
        out_std_next    = out_std_reg;
        out_energy_next = out_energy_reg;

        if (cfg_valid) begin
            unique case (cfg_index)
                wsee_pkg::CFG_ENERGY_OFFSET: offset_next = cfg_data;
                wsee_pkg::CFG_ENERGY_GAIN:   gain_next   = cfg_data[wsee_pkg::GAIN_W-1:0];
                default: begin
                    offset_next = offset_reg;
                end
            endcase
        end

        unique case (dp_cmd.op)
            wsee_pkg::OP_LOAD: begin
                sum_next = in_sum;
            end
            wsee_pkg::OP_SQ_OLD: begin
                prod_next = mul_p;
                if (window_full) begin
                    total_next = total_reg - wsee_pkg::TOTAL_W'(old_sum);
                end
            end
            wsee_pkg::OP_SQ_NEW: begin
                prod_next  = mul_p;
                total_next = total_reg + wsee_pkg::TOTAL_W'(sum_reg);
                if (window_full) begin
                    squares_next = squares_reg - wsee_pkg::SQUARES_W'(prod_reg);
                end
            end
            wsee_pkg::OP_ACC: begin
                squares_next  = squares_reg + wsee_pkg::SQUARES_W'(prod_reg);
                slot_next     = (slot_reg == wsee_pkg::SLOT_W'(wsee_pkg::WINDOW - 1))
                              ? '0 : slot_reg + 1'b1;
                full_res_next = dp_stat.fill_last;
                if (!window_full) begin
                    fill_next = fill_reg + 1'b1;
                end
            end
            wsee_pkg::OP_NQ: begin
                nq_next = wsee_pkg::NQ_W'(squares_reg) * wsee_pkg::NQ_W'(wsee_pkg::WINDOW);
            end
            wsee_pkg::OP_SS: begin
                prod_next = mul_p;
            end
            wsee_pkg::OP_DIFF: begin
                rad_next  = wsee_pkg::RAD_W'({diff, wsee_pkg::FRAC_SHIFT'(0)});
                root_next = '0;
                rem_next  = '0;
            end
            wsee_pkg::OP_SQRT: begin
                rad_next = rad_reg << 2;
                if (rem_trial >= root_trial) begin
                    rem_next  = rem_trial - root_trial;
                    root_next = {root_reg[wsee_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    rem_next  = rem_trial;
                    root_next = {root_reg[wsee_pkg::ROOT_W-2:0], 1'b0};
                end
            end
            wsee_pkg::OP_DIV: begin
                prod_next = mul_p;
            end
            wsee_pkg::OP_QEST: begin
                q_next = wsee_pkg::ROOT_W'(prod_reg >> wsee_pkg::RECIP_SHIFT);
            end
            wsee_pkg::OP_QFIX: begin
                if (q_resid >= wsee_pkg::ROOT_W'(wsee_pkg::WINDOW)) begin
                    sd_next = wsee_pkg::STD_W'(q_reg + 1'b1);
                end else begin
                    sd_next = wsee_pkg::STD_W'(q_reg);
                end
            end
            wsee_pkg::OP_GAIN: begin
                prod_next = mul_p;
            end
            wsee_pkg::OP_FINISH: begin
                out_valid_next  = 1'b1;
                out_ready_next  = full_res_reg;
                out_std_next    = full_res_reg ? sd_reg : '0;
                out_energy_next = full_res_reg ? energy_calc : '0;
            end
            default: begin
                sum_next = sum_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg      <= '0;
            fill_reg      <= '0;
            total_reg     <= '0;
            squares_reg   <= '0;
            full_res_reg  <= 1'b0;
            offset_reg    <= wsee_pkg::OFFSET_RESET;
            gain_reg      <= wsee_pkg::GAIN_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            slot_reg      <= slot_next;
            fill_reg      <= fill_next;
            total_reg     <= total_next;
            squares_reg   <= squares_next;
            full_res_reg  <= full_res_next;
            offset_reg    <= offset_next;
            gain_reg      <= gain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg        <= sum_next;
        prod_reg       <= prod_next;
        nq_reg         <= nq_next;
        rad_reg        <= rad_next;
        root_reg       <= root_next;
        rem_reg        <= rem_next;
        q_reg          <= q_next;
        sd_reg         <= sd_next;
        out_ready_reg  <= out_ready_next;
        out_std_reg    <= out_std_next;
        out_energy_reg <= out_energy_next;
    end

    assign dp_stat.fill_last = (fill_reg >= wsee_pkg::FILL_W'(wsee_pkg::WINDOW - 1));
    assign dp_stat.out_stall = out_valid_reg && !m_tready;

    assign m_tvalid  = out_valid_reg;
    assign ready_res = out_ready_reg;
    assign std_dev   = out_std_reg;
    assign energy    = out_energy_reg;

endmodule

/* sv/windowed_stdev_energy_estimator_unit.sv */
// ----------------------------------------------------------------------------
// Windowed standard deviation energy estimator
// Input is taken only in the idle state, so a new item is accepted only after
// the previous result has been loaded into the output register, which waits
// on m_tready; the 29-step bit-serial square root in the datapath runs only
// once the window is full.
// Synchronous active-low reset clears the running sums, fill count and write
// slot and loads the configuration registers with their default values.
// ----------------------------------------------------------------------------
module windowed_stdev_energy_estimator_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // pressure_a [11:0], pressure_b [23:12], pressure_c [35:24], pressure_d [47:36]
    input  logic [wsee_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // std_dev [20:0], energy [58:21], zero fill [63:59]
    output logic [wsee_pkg::M_TDATA_W-1:0]      m_tdata,
    // ready_res [0]
    output logic                                m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wsee_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [wsee_pkg::CFG_DATA_W-1:0]     cfg_data
);

    wsee_pkg::dp_cmd_t               dp_cmd;
    wsee_pkg::dp_status_t            dp_stat;
    logic [wsee_pkg::STD_W-1:0]      std_dev;
    logic [wsee_pkg::ENERGY_W-1:0]   energy;

    assign cfg_ready = aresetn;

    wsee_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .dp_stat (dp_stat),
        .dp_cmd  (dp_cmd)
    );

    wsee_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .dp_cmd    (dp_cmd),
        .dp_stat   (dp_stat),
        .pressure_a(s_tdata[11:0]),
        .pressure_b(s_tdata[23:12]),
        .pressure_c(s_tdata[35:24]),
        .pressure_d(s_tdata[47:36]),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .ready_res (m_tuser),
        .std_dev   (std_dev),
        .energy    (energy)
    );

    assign m_tdata = wsee_pkg::M_TDATA_W'({energy, std_dev});

    // A result that is not ready carries all-zero data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("not-ready result carries nonzero data");

    // Loading the output register always presents a result next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_cmd.op == wsee_pkg::OP_FINISH) |=> m_tvalid)
        else $error("output load did not raise m_tvalid");

    // After an input transfer the block stops taking input while it works.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in progress");

    // The output register is never overwritten while a result is stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> (dp_cmd.op != wsee_pkg::OP_FINISH))
        else $error("stalled result overwritten");

endmodule
